// ----- rtl/rpe_pkg.sv -----
// ----------------------------------------------------------------------------
// rpe_pkg
// Shared constants and types of the reservoir percentile estimator.
// ----------------------------------------------------------------------------
package rpe_pkg;

  localparam int unsigned MaxEntries = 256;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);

  localparam logic [31:0] DefaultSeed = 32'd2463534242;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic CFG_SIZE = 1'b0;
  localparam logic CFG_SEED = 1'b1;

  // Queued command between front and back.
  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] value;
    logic [16:0] frac;
  } cmd_t;

  // Advance the xorshift32 state one step.
  function automatic logic [31:0] xorshift(input logic [31:0] s);
    logic [31:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

// ----- rtl/reservoir_percentile_estimator.sv -----
// ----------------------------------------------------------------------------
// reservoir_percentile_estimator
// Reservoir sampling with an interpolated percentile query.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  in       | in_valid/in_stall  | req_type, sample_value, fraction_q16
//  out      | out_valid/out_stall| pct_value, is_empty, seen_count
//  cfg      | cfg_we             | cfg_idx, cfg_data
// An append or clear completes in S_IDLE; a replacing add goes via S_MUL, S_REPL.
// A query on n entries computes the rank, then per rank scans all n entries
// for each candidate value tried (up to rank+2), a second rank only when
// interpolating, then S_DONE, S_ADD and S_OUT; an empty query goes to S_OUT.
// Reset is synchronous; the RAM is never cleared, only the fill and seen counts.
// The two-entry queue keeps accepting, until full, while a result waits under stall.
module reservoir_percentile_estimator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] sample_value,
  input  logic [16:0] fraction_q16,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pct_value,
  output logic        is_empty,
  output logic [31:0] seen_count
);

  logic          q_valid;
  logic          q_pop;
  rpe_pkg::cmd_t q_cmd;

  rpe_front u_front (
    .clk, .rst, .in_valid, .in_stall, .req_type, .sample_value, .fraction_q16,
    .q_valid, .q_pop, .q_cmd
  );

  rpe_back u_back (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data, .q_valid, .q_pop, .q_cmd,
    .out_valid, .out_stall, .pct_value, .is_empty, .seen_count
  );

endmodule

// ----- rtl/rpe_ram.sv -----
// ----------------------------------------------------------------------------
// rpe_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write and read, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rpe_front.sv -----
// ----------------------------------------------------------------------------
// rpe_front
// Accept items, drop unknown requests, and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module rpe_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    req_type,
  input  logic [31:0]   sample_value,
  input  logic [16:0]   fraction_q16,
  output logic          q_valid,
  input  logic          q_pop,
  output rpe_pkg::cmd_t q_cmd
);

  rpe_pkg::cmd_t slot [2];
  logic          rd_ptr;
  logic          wr_ptr;
  logic [1:0]    count;
  logic          push;
  logic          keep;

  assign in_stall = (count == 2'd2);
  assign keep     = (req_type != rpe_pkg::REQ_NONE);
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slot[rd_ptr];

  // Store accepted items
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{req: req_type, value: sample_value, frac: fraction_q16};
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop && q_valid) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");

endmodule

// ----- rtl/rpe_back.sv -----
// ----------------------------------------------------------------------------
// rpe_back
// Execute add, clear and query; queries select ranks by counting passes.
// ----------------------------------------------------------------------------
module rpe_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_idx,
  input  logic [31:0]   cfg_data,
  input  logic          q_valid,
  output logic          q_pop,
  input  rpe_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [31:0]   pct_value,
  output logic          is_empty,
  output logic [31:0]   seen_count
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_REPL  = 4'd2;
  localparam logic [3:0] S_RANK  = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_NEXT  = 4'd6;
  localparam logic [3:0] S_INTP  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_ADD   = 4'd10;

  localparam int unsigned IW = rpe_pkg::IdxW;
  localparam int unsigned CW = rpe_pkg::CntW;

  logic [3:0]    state;
  logic [8:0]    size_reg;
  logic [31:0]   rng;
  logic [CW-1:0] fill;
  logic [31:0]   seen;
  rpe_pkg::cmd_t cmd;
  logic [CW-1:0] cap;
  logic [63:0]   prod;
  logic [33:0]   rank;
  logic [CW-1:0] lo;
  logic [15:0]   w;
  logic [CW-1:0] target;
  logic          second;
  logic [31:0]   cand;
  logic [31:0]   best;
  logic [CW-1:0] scan_i;
  logic [CW-1:0] less_cnt;
  logic [CW-1:0] leq_cnt;
  logic [31:0]   a_val;
  logic [31:0]   b_val;
  logic [47:0]   dprod;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [IW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;
  logic [16:0]   frac_sat;

  // Clamp capacity to 1..MaxEntries
  always_comb begin
    if (size_reg == 9'd0) begin
      cap = CW'(1);
    end else if (32'(size_reg) > rpe_pkg::MaxEntries) begin
      cap = CW'(rpe_pkg::MaxEntries);
    end else begin
      cap = CW'(size_reg);
    end
  end

  assign frac_sat  = (cmd.frac > 17'd65536) ? 17'd65536 : cmd.frac;
  assign ram_raddr = scan_i[IW-1:0];
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign out_valid = (state == S_OUT);

  // Write on append or replacement
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill[IW-1:0];
    if (state == S_IDLE && q_valid && q_cmd.req == rpe_pkg::REQ_ADD && fill < cap) begin
      ram_we = 1'b1;
    end else if (state == S_REPL && prod[63:32] < 32'(cap)) begin
      ram_we    = 1'b1;
      ram_waddr = prod[32+IW-1:32];
    end
  end

  rpe_ram #(.Width(32), .Depth(rpe_pkg::MaxEntries)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (state == S_IDLE ? q_cmd.value : cmd.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: adds, clears and rank selection passes
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      size_reg  <= 9'd256;
      rng       <= rpe_pkg::DefaultSeed;
      fill      <= '0;
      seen      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          rpe_pkg::CFG_SIZE: size_reg <= cfg_data[8:0];
          rpe_pkg::CFG_SEED: rng <= (cfg_data == 32'd0) ? rpe_pkg::DefaultSeed : cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd <= q_cmd;
            unique case (q_cmd.req)
              rpe_pkg::REQ_ADD: begin
                if (seen != 32'hFFFF_FFFF) seen <= seen + 32'd1;
                if (fill < cap) begin
                  fill <= fill + CW'(1);
                end else begin
                  rng   <= rpe_pkg::xorshift(rng);
                  state <= S_MUL;
                end
              end
              rpe_pkg::REQ_CLEAR: begin
                fill <= '0;
                seen <= '0;
              end
              rpe_pkg::REQ_QUERY: begin
                if (fill == '0) begin
                  pct_value  <= 32'd0;
                  is_empty   <= 1'b1;
                  seen_count <= seen;
                  state      <= S_OUT;
                end else begin
                  state <= S_RANK;
                end
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          prod  <= 64'(rng) * 64'(seen);
          state <= S_REPL;
        end
        S_REPL: state <= S_IDLE;
        S_RANK: begin
          rank  <= 34'(frac_sat) * 34'(fill - CW'(1));
          state <= S_SCAN;
          second <= 1'b0;
        end
        S_SCAN: begin
          // Begin a pass: pick rank target, reset candidate search
          lo        <= (second) ? lo : CW'(rank[33:16]);
          w         <= (second) ? w : rank[15:0];
          target    <= second ? lo + CW'(1) : CW'(rank[33:16]);
          cand      <= 32'd0;
          scan_i    <= '0;
          less_cnt  <= '0;
          leq_cnt   <= '0;
          state     <= S_CMP;
        end
        S_CMP: begin
          // Read data for scan_i arrives next cycle
          state <= S_NEXT;
        end
        S_NEXT: begin
          // Count entries below and at the candidate value
          if (ram_rdata < cand) less_cnt <= less_cnt + CW'(1);
          if (ram_rdata <= cand) leq_cnt <= leq_cnt + CW'(1);
          if (scan_i + CW'(1) == fill) begin
            scan_i <= '0;
            state  <= S_INTP;
          end else begin
            scan_i <= scan_i + CW'(1);
            state  <= S_CMP;
          end
        end
        S_INTP: begin
          // Candidate holds rank target iff less <= target < leq
          if (less_cnt <= target && target < leq_cnt) begin
            if (!second) a_val <= cand; else b_val <= cand;
            if (!second && w != 16'd0 && lo + CW'(1) < fill) begin
              second <= 1'b1;
              state  <= S_SCAN;
            end else begin
              if (!second) b_val <= cand;
              state <= S_DONE;
            end
          end else begin
            // Move to next candidate: the smallest value above cand
            state     <= S_CMP;
            cand      <= best;
            less_cnt  <= '0;
            leq_cnt   <= '0;
          end
        end
        S_DONE: begin
          dprod <= 48'(b_val - a_val) * 48'(second ? w : 16'd0);
          state <= S_ADD;
        end
        S_ADD: begin
          // Add the scaled difference to the lower rank value
          pct_value  <= a_val + dprod[47:16];
          is_empty   <= 1'b0;
          seen_count <= seen;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Track the smallest entry above the candidate during a pass
  always_ff @(posedge clk) begin
    if (state == S_SCAN || state == S_INTP) begin
      best <= 32'hFFFF_FFFF;
    end else if (state == S_NEXT && ram_rdata > cand && ram_rdata < best) begin
      best <= ram_rdata;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= rpe_pkg::MaxEntries) else $error("fill beyond depth");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE) else $error("pop while busy");

endmodule
